>>> hw/rtl/roller_jam_detect_unjam_top_defines.svh
// assertion macros used by the roller jam controller checker
`ifndef ROLLER_JAM_DETECT_UNJAM_TOP_DEFINES_SVH
`define ROLLER_JAM_DETECT_UNJAM_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RJDU_ASSERT_NOW(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error("roller jam controller check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define RJDU_ASSERT_NEXT(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error("roller jam controller check failed");

`endif

>>> hw/rtl/rjdu_pkg.sv
// shared types, codes and helpers for the roller jam controller
package rjdu_pkg;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// command codes
	localparam logic [2:0] CMD_IDLE    = 3'd0;
	localparam logic [2:0] CMD_INTAKE  = 3'd1;
	localparam logic [2:0] CMD_OUTTAKE = 3'd2;
	localparam logic [2:0] CMD_EJECT   = 3'd3;
	localparam logic [2:0] CMD_UNJAM   = 3'd4;

	// reported roller mode codes
	localparam logic [2:0] RM_IDLE    = 3'd0;
	localparam logic [2:0] RM_INTAKE  = 3'd1;
	localparam logic [2:0] RM_OUTTAKE = 3'd2;
	localparam logic [2:0] RM_EJECT   = 3'd3;
	localparam logic [2:0] RM_UNJAM   = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_JAM_CURRENT_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_SPEED_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TICKS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNJAM_TICKS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTAKE_SPEED      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTTAKE_SPEED     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EJECT_SPEED       = 3'd6;

	// register reset values
	localparam logic [11:0]        RST_JAM_CURRENT_LIMIT = 12'd320;
	localparam logic [14:0]        RST_STALL_SPEED_LIMIT = 15'd100;
	localparam logic [15:0]        RST_CONFIRM_TICKS     = 16'd25;
	localparam logic [15:0]        RST_UNJAM_TICKS       = 16'd25;
	localparam logic signed [15:0] RST_INTAKE_SPEED      = 16'sd3000;
	localparam logic signed [15:0] RST_OUTTAKE_SPEED     = -16'sd2000;
	localparam logic signed [15:0] RST_EJECT_SPEED       = -16'sd3000;

	// roller mode state, one-hot
	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_INTAKE  = 5'b00010,
		MODE_OUTTAKE = 5'b00100,
		MODE_EJECT   = 5'b01000,
		MODE_UNJAM   = 5'b10000
	} mode_t;

	typedef struct packed {
		logic               mode;
		logic [2:0]         command;
		logic [11:0]        current_sample;
		logic signed [15:0] speed_sample;
	} item_t;

	typedef struct packed {
		logic [2:0]         roller_mode;
		logic               drive_velocity;
		logic signed [15:0] speed_setpoint;
		logic               jam_pending;
	} result_t;

	typedef struct packed {
		logic [11:0]        jam_current_limit;
		logic [14:0]        stall_speed_limit;
		logic [15:0]        confirm_ticks;
		logic [15:0]        unjam_ticks;
		logic signed [15:0] intake_speed;
		logic signed [15:0] outtake_speed;
		logic signed [15:0] eject_speed;
	} cfg_t;

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
	endfunction

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] code;
		case (m)
			MODE_INTAKE:  code = RM_INTAKE;
			MODE_OUTTAKE: code = RM_OUTTAKE;
			MODE_EJECT:   code = RM_EJECT;
			MODE_UNJAM:   code = RM_UNJAM;
			default:      code = RM_IDLE;
		endcase
		return code;
	endfunction

endpackage

>>> hw/rtl/rjdu_ifs.sv
// valid/ready channel interfaces of the roller jam controller

interface rjdu_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [2:0]         command;
	logic [11:0]        current_sample;
	logic signed [15:0] speed_sample;

	modport source (output valid, mode, command, current_sample, speed_sample, input ready);
	modport sink (input valid, mode, command, current_sample, speed_sample, output ready);
endinterface

interface rjdu_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         roller_mode;
	logic               drive_velocity;
	logic signed [15:0] speed_setpoint;
	logic               jam_pending;

	modport source (output valid, roller_mode, drive_velocity, speed_setpoint, jam_pending,
		input ready);
	modport sink (input valid, roller_mode, drive_velocity, speed_setpoint, jam_pending,
		output ready);
endinterface

interface rjdu_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rjdu_pkg::CFG_IDX_W-1:0]     index;
	logic [rjdu_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/roller_jam_detect_unjam_top.sv
// top level of the roller mode controller with jam recovery
//
// usage:
// - items: one transaction per tick (samples) or mode command; each yields
//   exactly one transaction on results with mode, drive type and setpoint
// - cfg: register writes, always ready; write only while the block is idle
// - order: the accepting edge loads the input register; the item moves
//   into the result register once it is free, raising results.valid
// - throughput: one item per cycle unless results is held off; state
//   update and result both come from a single pass of compare and
//   counter logic between the two registers
// - stall: when results is held off, the result register keeps its value;
//   the input register still takes one more item, after which items.ready
//   drops until the result is taken
// - reset: arst_n clears both valid flags, the mode to idle, the jam flag
//   and both tick counters, and loads the register reset values
module roller_jam_detect_unjam_top (
	input  logic       clk,
	input  logic       arst_n,
	rjdu_in_if.sink    items,
	rjdu_out_if.source results,
	rjdu_cfg_if.sink   cfg
);

	// input stage
	logic              valid_s1;
	rjdu_pkg::item_t   item_s1;
	// result stage
	logic              valid_s2;
	rjdu_pkg::result_t result_s2;

	rjdu_pkg::cfg_t    cfg_regs;
	rjdu_pkg::result_t result_next;
	logic              advance;

	// item in the input register moves into the result register
	assign advance     = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready = !valid_s1 || advance;

	rjdu_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// state moves exactly once per item, when that item advances
	rjdu_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg_regs),
		.result  (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (!valid_s2 || results.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.mode           <= items.mode;
			item_s1.command        <= items.command;
			item_s1.current_sample <= items.current_sample;
			item_s1.speed_sample   <= items.speed_sample;
		end
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign results.valid          = valid_s2;
	assign results.roller_mode    = result_s2.roller_mode;
	assign results.drive_velocity = result_s2.drive_velocity;
	assign results.speed_setpoint = result_s2.speed_setpoint;
	assign results.jam_pending    = result_s2.jam_pending;

endmodule

>>> hw/rtl/rjdu_cfg_regs.sv
// configuration register file of the roller jam controller
module rjdu_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	rjdu_cfg_if.sink         cfg,
	output rjdu_pkg::cfg_t   regs
);

	rjdu_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.jam_current_limit <= rjdu_pkg::RST_JAM_CURRENT_LIMIT;
			regs_q.stall_speed_limit <= rjdu_pkg::RST_STALL_SPEED_LIMIT;
			regs_q.confirm_ticks     <= rjdu_pkg::RST_CONFIRM_TICKS;
			regs_q.unjam_ticks       <= rjdu_pkg::RST_UNJAM_TICKS;
			regs_q.intake_speed      <= rjdu_pkg::RST_INTAKE_SPEED;
			regs_q.outtake_speed     <= rjdu_pkg::RST_OUTTAKE_SPEED;
			regs_q.eject_speed       <= rjdu_pkg::RST_EJECT_SPEED;
		end else if (cfg.valid) begin
			case (cfg.index)
				rjdu_pkg::CFG_JAM_CURRENT_LIMIT: regs_q.jam_current_limit <= cfg.data[11:0];
				rjdu_pkg::CFG_STALL_SPEED_LIMIT: regs_q.stall_speed_limit <= cfg.data[14:0];
				rjdu_pkg::CFG_CONFIRM_TICKS:     regs_q.confirm_ticks     <= cfg.data;
				rjdu_pkg::CFG_UNJAM_TICKS:       regs_q.unjam_ticks       <= cfg.data;
				rjdu_pkg::CFG_INTAKE_SPEED:      regs_q.intake_speed      <= $signed(cfg.data);
				rjdu_pkg::CFG_OUTTAKE_SPEED:     regs_q.outtake_speed     <= $signed(cfg.data);
				rjdu_pkg::CFG_EJECT_SPEED:       regs_q.eject_speed       <= $signed(cfg.data);
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/rjdu_core.sv
// roller mode state, jam detection and unjam timing
module rjdu_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  rjdu_pkg::item_t   item,
	input  rjdu_pkg::cfg_t    cfg,
	output rjdu_pkg::result_t result
);

	rjdu_pkg::mode_t mode_q, mode_n;
	logic            jam_pending_q, jam_pending_n;
	logic [15:0]     jam_count_q, jam_count_n;
	logic [15:0]     reverse_count_q, reverse_count_n;

	logic [15:0] speed_mag;
	logic        jam;
	logic [15:0] jam_inc;
	logic [15:0] rev_inc;

	// magnitude fits 16 unsigned bits, most negative speed gives 32768
	assign speed_mag = item.speed_sample[15] ? (~item.speed_sample + 16'd1)
		: item.speed_sample;
	assign jam = (item.current_sample > cfg.jam_current_limit)
		&& (speed_mag < {1'b0, cfg.stall_speed_limit});
	assign jam_inc = rjdu_pkg::sat_inc16(jam_pending_q ? jam_count_q : 16'd0);
	assign rev_inc = rjdu_pkg::sat_inc16(reverse_count_q);

	always_comb begin
		mode_n          = mode_q;
		jam_pending_n   = jam_pending_q;
		jam_count_n     = jam_count_q;
		reverse_count_n = reverse_count_q;
		if (item.mode == rjdu_pkg::KIND_CMD) begin
			case (item.command)
				rjdu_pkg::CMD_IDLE:    mode_n = rjdu_pkg::MODE_IDLE;
				rjdu_pkg::CMD_INTAKE:  mode_n = rjdu_pkg::MODE_INTAKE;
				rjdu_pkg::CMD_OUTTAKE: mode_n = rjdu_pkg::MODE_OUTTAKE;
				rjdu_pkg::CMD_EJECT:   mode_n = rjdu_pkg::MODE_EJECT;
				rjdu_pkg::CMD_UNJAM:   mode_n = mode_q;
				default:               mode_n = rjdu_pkg::MODE_IDLE;
			endcase
		end else if (mode_q == rjdu_pkg::MODE_INTAKE) begin
			if (jam) begin
				jam_pending_n = 1'b1;
				jam_count_n   = jam_inc;
				if (jam_inc >= cfg.confirm_ticks) begin
					jam_pending_n   = 1'b0;
					mode_n          = rjdu_pkg::MODE_UNJAM;
					reverse_count_n = 16'd0;
				end
			end else begin
				jam_pending_n = 1'b0;
			end
		end else if (mode_q == rjdu_pkg::MODE_UNJAM) begin
			reverse_count_n = rev_inc;
			if (rev_inc >= cfg.unjam_ticks) begin
				mode_n = rjdu_pkg::MODE_INTAKE;
			end
		end
	end

	always_comb begin
		result.roller_mode    = rjdu_pkg::mode_code(mode_n);
		result.drive_velocity = (mode_n != rjdu_pkg::MODE_IDLE);
		result.jam_pending    = jam_pending_n;
		case (mode_n)
			rjdu_pkg::MODE_INTAKE:  result.speed_setpoint = cfg.intake_speed;
			rjdu_pkg::MODE_OUTTAKE: result.speed_setpoint = cfg.outtake_speed;
			rjdu_pkg::MODE_EJECT:   result.speed_setpoint = cfg.eject_speed;
			rjdu_pkg::MODE_UNJAM:   result.speed_setpoint = cfg.eject_speed;
			default:                result.speed_setpoint = 16'sd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= rjdu_pkg::MODE_IDLE;
			jam_pending_q   <= 1'b0;
			jam_count_q     <= 16'd0;
			reverse_count_q <= 16'd0;
		end else if (step_en) begin
			mode_q          <= mode_n;
			jam_pending_q   <= jam_pending_n;
			jam_count_q     <= jam_count_n;
			reverse_count_q <= reverse_count_n;
		end
	end

endmodule

>>> hw/rtl/rjdu_checker.sv
// port-level checks of the roller jam controller, bound to the top level
`include "roller_jam_detect_unjam_top_defines.svh"

module rjdu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [2:0]         roller_mode,
	input logic               drive_velocity,
	input logic signed [15:0] speed_setpoint,
	input logic               jam_pending
);

	// drive type follows the reported mode
	`RJDU_ASSERT_NOW(a_drive_matches_mode, out_valid, drive_velocity == (roller_mode != rjdu_pkg::RM_IDLE))

	// mode code stays in its range
	`RJDU_ASSERT_NOW(a_mode_in_range, out_valid, roller_mode <= rjdu_pkg::RM_UNJAM)

	// idle always reports a zero setpoint
	`RJDU_ASSERT_NOW(a_idle_zero_speed, out_valid && (roller_mode == rjdu_pkg::RM_IDLE), speed_setpoint == 16'sd0)

	// a stalled result holds
	`RJDU_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(roller_mode) && $stable(drive_velocity) && $stable(speed_setpoint) && $stable(jam_pending))

endmodule

bind roller_jam_detect_unjam_top rjdu_checker u_rjdu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.roller_mode    (results.roller_mode),
	.drive_velocity (results.drive_velocity),
	.speed_setpoint (results.speed_setpoint),
	.jam_pending    (results.jam_pending)
);
